@@ design/chhf_pkg.sv @@
// Package for the correlated heavy hitter filter: widths, request codes,
// verdict codes, register indexes, queue entry and sequencer state types.
// No dependencies.
package chhf_pkg;

    localparam int DEF_PRIMARY_SLOTS = 128;

    localparam int KEY_W      = 32;
    localparam int COUNT_W    = 32;
    localparam int FRAC_W     = 16;
    localparam int OFFSET_W   = 40;
    localparam int SCALE_BITS = 8;
    localparam int PROD_W     = FRAC_W + OFFSET_W;
    localparam int REQ_W      = 2;
    localparam int VERDICT_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [REQ_W-1:0] t_req_type;
    localparam t_req_type REQ_CLEAR      = 2'd0;
    localparam t_req_type REQ_PRIMARY    = 2'd1;
    localparam t_req_type REQ_CORRELATED = 2'd2;

    typedef logic [VERDICT_W-1:0] t_verdict;
    localparam t_verdict V_REJECT     = 3'd0;
    localparam t_verdict V_PRIMARY    = 3'd1;
    localparam t_verdict V_CORRELATED = 3'd2;
    localparam t_verdict V_UNKNOWN    = 3'd3;
    localparam t_verdict V_FULL       = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRACTION  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 2'd2;

    localparam logic [FRAC_W-1:0] FRACTION_RESET = 16'd655;

    // OP_PASS: answered with verdict zero, table untouched
    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_PASS,
        OP_PRIMARY,
        OP_CORRELATED
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [KEY_W-1:0]   pkey;
        logic [KEY_W-1:0]   skey;
        logic [COUNT_W-1:0] cnt;
    } t_req;

    typedef struct packed {
        logic [FRAC_W-1:0]   fraction;
        logic [OFFSET_W-1:0] offset;
    } t_corr_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DIFF,
        S_MUL,
        S_DECIDE
    } t_state;

endpackage

@@ design/chhf_front.sv @@
// Front end: configuration registers, request classification and push into
// the request queue. Depends on chhf_pkg.
module chhf_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [chhf_pkg::REQ_W-1:0]     i_req_type,
    input  logic [chhf_pkg::KEY_W-1:0]     i_primary_key,
    input  logic [chhf_pkg::KEY_W-1:0]     i_secondary_key,
    input  logic [chhf_pkg::COUNT_W-1:0]   i_item_count,
    input  logic                           i_cfg_valid,
    input  logic [chhf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [chhf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_cfg_ready,
    input  logic                           i_full,
    output logic                           o_push,
    output chhf_pkg::t_req                 o_req,
    output chhf_pkg::t_corr_cfg            o_corr_cfg
);
    import chhf_pkg::*;

    logic [COUNT_W-1:0]  r_threshold;
    logic [FRAC_W-1:0]   r_fraction;
    logic [OFFSET_W-1:0] r_offset;
    t_op                 w_op;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_fraction  <= FRACTION_RESET;
            r_offset    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= i_cfg_data[COUNT_W-1:0];
                CFG_FRACTION:  r_fraction  <= i_cfg_data[FRAC_W-1:0];
                CFG_OFFSET:    r_offset    <= i_cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // threshold test done here so the back end only sees table work
    always_comb begin
        case (i_req_type)
            REQ_CLEAR:      w_op = OP_CLEAR;
            REQ_PRIMARY:    w_op = (i_item_count > r_threshold) ? OP_PRIMARY : OP_PASS;
            REQ_CORRELATED: w_op = OP_CORRELATED;
            default:        w_op = OP_PASS;
        endcase
    end

    assign o_push      = i_start && !i_full;
    assign o_req.op    = w_op;
    assign o_req.pkey  = i_primary_key;
    assign o_req.skey  = i_secondary_key;
    assign o_req.cnt   = i_item_count;

    assign o_corr_cfg.fraction = r_fraction;
    assign o_corr_cfg.offset   = r_offset;

endmodule

@@ design/chhf_fifo.sv @@
// Short request queue between front end and back end.
// Depends on chhf_pkg.
module chhf_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  chhf_pkg::t_req i_req,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output chhf_pkg::t_req o_req
);
    import chhf_pkg::*;

    t_req              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_req   = r_mem[r_rd_ptr];

endmodule

@@ design/chhf_back.sv @@
// Back end: table memories, linear key search, exact correlated threshold
// test and result register. Depends on chhf_pkg.
module chhf_back #(
    parameter int PRIMARY_SLOTS = chhf_pkg::DEF_PRIMARY_SLOTS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  chhf_pkg::t_req                 i_req,
    output logic                           o_pop,
    input  chhf_pkg::t_corr_cfg            i_corr_cfg,
    output logic                           o_done,
    output logic [chhf_pkg::VERDICT_W-1:0] o_verdict,
    output logic [chhf_pkg::KEY_W-1:0]     o_primary_key,
    output logic [chhf_pkg::KEY_W-1:0]     o_secondary_key,
    output logic [chhf_pkg::COUNT_W-1:0]   o_count,
    output logic [chhf_pkg::COUNT_W-1:0]   o_found_count
);
    import chhf_pkg::*;

    localparam int AW = $clog2(PRIMARY_SLOTS);
    localparam int FW = $clog2(PRIMARY_SLOTS + 1);

    logic [KEY_W-1:0]   r_keys   [PRIMARY_SLOTS];
    logic [COUNT_W-1:0] r_counts [PRIMARY_SLOTS];

    t_state              r_state, n_state;
    t_req                r_item;
    logic [FW-1:0]       r_fill;
    logic [FW-1:0]       r_addr;
    logic                r_cmp_valid;
    logic [AW-1:0]       r_cmp_addr;
    logic [KEY_W-1:0]    r_key_rd;
    logic [COUNT_W-1:0]  r_cnt_rd;
    logic [COUNT_W-1:0]  r_found;
    logic                r_lt;
    logic                r_eq;
    logic [OFFSET_W-1:0] r_diff;
    logic [PROD_W-1:0]   r_prod;

    logic                r_done;
    t_verdict            r_verdict;
    logic [KEY_W-1:0]    r_pkey_out;
    logic [KEY_W-1:0]    r_skey_out;
    logic [COUNT_W-1:0]  r_cnt_out;
    logic [COUNT_W-1:0]  r_found_out;

    logic                w_hit;
    logic                w_miss;
    logic                w_issue;
    logic                w_emit;
    t_verdict            w_verdict;
    logic [COUNT_W-1:0]  w_found;
    t_req                w_echo;
    logic                w_key_we;
    logic                w_cnt_we;
    logic [AW-1:0]       w_wr_addr;
    logic                w_fill_clr;
    logic                w_fill_inc;
    logic [OFFSET_W:0]   w_sub;
    logic [PROD_W-1:0]   w_lhs;

    // read data of r_cmp_addr arrives in the cycle after the address was issued
    assign w_hit   = (r_state == S_SEARCH) && r_cmp_valid && (r_key_rd == r_item.pkey);
    assign w_miss  = (r_state == S_SEARCH) && !w_hit && (r_addr == r_fill);
    assign w_issue = (r_state == S_SEARCH) && (r_addr != r_fill);

    assign w_sub = {1'b0, r_found, {SCALE_BITS{1'b0}}} - {1'b0, i_corr_cfg.offset};
    assign w_lhs = {r_item.cnt, {(PROD_W - COUNT_W){1'b0}}};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid && (i_req.op == OP_PRIMARY || i_req.op == OP_CORRELATED)) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_hit) begin
                    n_state = (r_item.op == OP_CORRELATED) ? S_DIFF : S_IDLE;
                end else if (w_miss) begin
                    n_state = S_IDLE;
                end
            end
            S_DIFF:   n_state = S_MUL;
            S_MUL:    n_state = S_DECIDE;
            S_DECIDE: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop      = 1'b0;
        w_emit     = 1'b0;
        w_verdict  = V_REJECT;
        w_found    = '0;
        w_echo     = r_item;
        w_key_we   = 1'b0;
        w_cnt_we   = 1'b0;
        w_wr_addr  = r_cmp_addr;
        w_fill_clr = 1'b0;
        w_fill_inc = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_pop  = i_valid;
                w_echo = i_req;
                if (i_valid && (i_req.op == OP_CLEAR || i_req.op == OP_PASS)) begin
                    w_emit     = 1'b1;
                    w_fill_clr = (i_req.op == OP_CLEAR);
                end
            end
            S_SEARCH: begin
                if (w_hit && r_item.op == OP_PRIMARY) begin
                    w_emit    = 1'b1;
                    w_verdict = V_PRIMARY;
                    w_found   = r_cnt_rd;
                    w_cnt_we  = 1'b1;
                end else if (w_miss && r_item.op == OP_PRIMARY) begin
                    w_emit    = 1'b1;
                    w_wr_addr = r_fill[AW-1:0];
                    if (r_fill != FW'(PRIMARY_SLOTS)) begin
                        w_verdict  = V_PRIMARY;
                        w_key_we   = 1'b1;
                        w_cnt_we   = 1'b1;
                        w_fill_inc = 1'b1;
                    end else begin
                        w_verdict = V_FULL;
                    end
                end else if (w_miss) begin
                    w_emit    = 1'b1;
                    w_verdict = V_UNKNOWN;
                end
            end
            S_DECIDE: begin
                w_emit  = 1'b1;
                w_found = r_found;
                // stored count below offset: threshold negative, all pass
                if (r_lt) begin
                    w_verdict = V_CORRELATED;
                end else if (r_eq) begin
                    w_verdict = (r_item.cnt != '0) ? V_CORRELATED : V_REJECT;
                end else begin
                    w_verdict = (w_lhs > r_prod) ? V_CORRELATED : V_REJECT;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            r_keys[w_wr_addr] <= r_item.pkey;
        end
        r_key_rd <= r_keys[r_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_cnt_we) begin
            r_counts[w_wr_addr] <= r_item.cnt;
        end
        r_cnt_rd <= r_counts[r_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_addr      <= '0;
            r_cmp_valid <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= w_emit;
            if (w_fill_clr) begin
                r_fill <= '0;
            end else if (w_fill_inc) begin
                r_fill <= r_fill + 1'b1;
            end
            if (r_state == S_IDLE) begin
                r_addr      <= '0;
                r_cmp_valid <= 1'b0;
            end else begin
                r_cmp_valid <= w_issue;
                if (w_issue) begin
                    r_addr <= r_addr + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_req;
        end
        r_cmp_addr <= r_addr[AW-1:0];
        if (w_hit) begin
            r_found <= r_cnt_rd;
        end
        if (r_state == S_DIFF) begin
            {r_lt, r_diff} <= w_sub;
        end
        if (r_state == S_MUL) begin
            r_eq   <= (r_diff == '0);
            r_prod <= PROD_W'(i_corr_cfg.fraction) * PROD_W'(r_diff);
        end
        if (w_emit) begin
            r_verdict   <= w_verdict;
            r_pkey_out  <= w_echo.pkey;
            r_skey_out  <= w_echo.skey;
            r_cnt_out   <= w_echo.cnt;
            r_found_out <= w_found;
        end
    end

    assign o_done          = r_done;
    assign o_verdict       = r_verdict;
    assign o_primary_key   = r_pkey_out;
    assign o_secondary_key = r_skey_out;
    assign o_count         = r_cnt_out;
    assign o_found_count   = r_found_out;

endmodule

@@ design/correlated_heavy_hitter_filter_core.sv @@
// Clear and pass-through requests are answered straight from idle; other requests search
// the table, and correlated hits then go through the exact test in S_DIFF, S_MUL, S_DECIDE.
// The back end finishes one request before it pops the next, and the key memory is scanned
// one entry a cycle; the search ends at a hit or after the last filled entry;
// a 2-deep queue absorbs requests, o_busy is high while it is full. Results cannot be
// stalled. Reset (sync, active low) empties the table and restores register defaults.
module correlated_heavy_hitter_filter_core #(
    parameter int PRIMARY_SLOTS = chhf_pkg::DEF_PRIMARY_SLOTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [chhf_pkg::REQ_W-1:0]      i_req_type,
    input  logic [chhf_pkg::KEY_W-1:0]      i_primary_key,
    input  logic [chhf_pkg::KEY_W-1:0]      i_secondary_key,
    input  logic [chhf_pkg::COUNT_W-1:0]    i_item_count,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [chhf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [chhf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_done,
    output logic [chhf_pkg::VERDICT_W-1:0]  o_verdict,
    output logic [chhf_pkg::KEY_W-1:0]      o_out_primary_key,
    output logic [chhf_pkg::KEY_W-1:0]      o_out_secondary_key,
    output logic [chhf_pkg::COUNT_W-1:0]    o_out_count,
    output logic [chhf_pkg::COUNT_W-1:0]    o_found_primary_count
);
    import chhf_pkg::*;

    logic      w_full;
    logic      w_push;
    logic      w_q_valid;
    logic      w_pop;
    t_req      w_push_req;
    t_req      w_head_req;
    t_corr_cfg w_corr_cfg;

    assign o_busy = w_full;

    chhf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_req_type      (i_req_type),
        .i_primary_key   (i_primary_key),
        .i_secondary_key (i_secondary_key),
        .i_item_count    (i_item_count),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_cfg_ready     (o_cfg_ready),
        .i_full          (w_full),
        .o_push          (w_push),
        .o_req           (w_push_req),
        .o_corr_cfg      (w_corr_cfg)
    );

    chhf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_push_req),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_req   (w_head_req)
    );

    chhf_back #(
        .PRIMARY_SLOTS (PRIMARY_SLOTS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_q_valid),
        .i_req           (w_head_req),
        .o_pop           (w_pop),
        .i_corr_cfg      (w_corr_cfg),
        .o_done          (o_done),
        .o_verdict       (o_verdict),
        .o_primary_key   (o_out_primary_key),
        .o_secondary_key (o_out_secondary_key),
        .o_count         (o_out_count),
        .o_found_count   (o_found_primary_count)
    );

endmodule

@@ design/chhf_chk.sv @@
// Port-level checker for the correlated heavy hitter filter, bound to the
// top level. Depends on chhf_pkg.
module chhf_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_start,
    input logic                            o_busy,
    input logic                            o_done,
    input logic [chhf_pkg::VERDICT_W-1:0]  o_verdict,
    input logic [chhf_pkg::COUNT_W-1:0]    o_out_count,
    input logic [chhf_pkg::COUNT_W-1:0]    o_found_primary_count
);
    import chhf_pkg::*;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done && !o_busy)
        else $error("result or busy right after reset");

    a_no_hit_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_verdict == V_UNKNOWN || o_verdict == V_FULL)
        |-> o_found_primary_count == '0)
        else $error("found count reported without a table hit");

    // stored counts were above a nonnegative threshold when written, so never zero
    a_corr_found_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_verdict == V_CORRELATED |-> o_found_primary_count != '0)
        else $error("correlated pass with zero stored count");

    a_primary_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_verdict == V_PRIMARY |-> o_out_count != '0)
        else $error("primary kept with zero count");

    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start))
        else $error("busy rose without a request");

endmodule

bind correlated_heavy_hitter_filter_core chhf_chk u_chhf_chk (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_start               (i_start),
    .o_busy                (o_busy),
    .o_done                (o_done),
    .o_verdict             (o_verdict),
    .o_out_count           (o_out_count),
    .o_found_primary_count (o_found_primary_count)
);
